[sv/tlsd_pkg.sv]
// shared types and codes for the tagged-length segment deframer
// no dependencies; used by tlsd_parser and the core top level

package tlsd_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_TRUNC        = 2'd1;
    localparam logic [1:0] STATUS_BAD_PREAMBLE = 2'd2;
    localparam logic [1:0] STATUS_BAD_FRAME    = 2'd3;

    // one result request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       segment_kind;
        logic       segment_end;
        logic [1:0] status;
        logic       stream_end;
    } result_t;

endpackage

[sv/tagged_length_segment_deframer_core.sv]
// top level of the tagged-length segment deframer
// depends on tlsd_pkg and tlsd_parser

// Takes a raw byte stream of repeating segment pairs (tag 0x01, 32-bit
// big-endian length, preamble bytes; tag 0x02, 32-bit big-endian length,
// frame bytes) and returns one result request per payload byte, one empty
// marker per zero-length segment, and status requests for a bad tag, for a
// stream whose last byte falls inside a pair (truncated), or a clean end at
// a pair boundary (stream_end). After a bad tag, input is swallowed with no
// results up to and including the last byte; any last byte returns the
// parser to its reset state. Header bytes give no result apart from those
// cases. Rate: one input byte per clock unless stalled. The parser state
// update is a single pass of short logic (a 32-bit decrement and compare)
// between the accepted byte and the output register, so a result lands in
// the output register (or the skid register while the output is held) as
// its byte is taken. A two-entry output stage (output register plus skid
// register) parts the sides: input is stalled only while the skid register
// holds a result, i.e. after the consumer has stalled with a result pending
// and another result has followed. No clearing pass after reset.

module tagged_length_segment_deframer_core
(
    input  logic       clk,
    input  logic       rst_n,

    // input request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last,

    // result request channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       segment_kind,
    output logic       segment_end,
    output logic [1:0] status,
    output logic       stream_end
);

    logic                in_accept;
    logic                out_take;
    logic                emit;
    tlsd_pkg::result_t   result;
    logic                out_valid_reg;
    tlsd_pkg::result_t   out_data_reg;
    logic                skid_valid_reg;
    tlsd_pkg::result_t   skid_data_reg;

    // stall only once the skid slot is taken
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    tlsd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .in_byte (in_byte),
        .last    (last),
        .emit    (emit),
        .result  (result)
    );

    // control of the output register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no input taken; drain skid into the output register
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_take)
        begin
            // output held by the consumer: new result parks in skid
            skid_valid_reg <= in_accept && emit;
        end
        else
        begin
            out_valid_reg <= in_accept && emit;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_data_reg <= skid_data_reg;
        end
        else if (out_valid_reg && !out_take)
        begin
            if (in_accept && emit)
                skid_data_reg <= result;
        end
        else if (in_accept && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_data_reg.out_byte;
    assign has_byte     = out_data_reg.has_byte;
    assign segment_kind = out_data_reg.segment_kind;
    assign segment_end  = out_data_reg.segment_end;
    assign status       = out_data_reg.status;
    assign stream_end   = out_data_reg.stream_end;

`ifndef SYNTH
    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_byte_never_bad_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_byte) |->
            (status == tlsd_pkg::STATUS_OK || status == tlsd_pkg::STATUS_TRUNC))
        else $error("payload byte carries a bad-tag status");

    a_clean_end_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_end) |-> status == tlsd_pkg::STATUS_OK)
        else $error("stream end reported with non-ok status");

    a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !skid_valid_reg && !in_accept) |=> !out_valid_reg)
        else $error("result appeared with no accepted byte");
`endif

endmodule

[sv/tlsd_parser.sv]
// segment parser: phase, length assembly and payload count for the deframer
// depends on tlsd_pkg (result_t, status codes)

module tlsd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                last,
    output logic                emit,
    output tlsd_pkg::result_t   result
);

    localparam logic [2:0] PH_PTAG  = 3'd0;
    localparam logic [2:0] PH_PLEN  = 3'd1;
    localparam logic [2:0] PH_PDATA = 3'd2;
    localparam logic [2:0] PH_FTAG  = 3'd3;
    localparam logic [2:0] PH_FLEN  = 3'd4;
    localparam logic [2:0] PH_FDATA = 3'd5;
    localparam logic [2:0] PH_ERR   = 3'd6;
    localparam logic [2:0] PH_SPARE = 3'd7;

    localparam logic [7:0] TAG_PREAMBLE = 8'h01;
    localparam logic [7:0] TAG_FRAME    = 8'h02;

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [1:0]  header_count_reg;
    logic [1:0]  header_count_next;
    logic [31:0] length_accum_reg;
    logic [31:0] length_accum_next;
    logic [31:0] bytes_left_reg;
    logic [31:0] bytes_left_next;
    logic [31:0] accum_shift;
    logic [31:0] bytes_dec;
    logic        is_frame;
    logic        bad_tag;

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        accum_shift       = {length_accum_reg[23:0], in_byte};
        bytes_dec         = bytes_left_reg - 32'd1;
        is_frame          = 1'b0;
        bad_tag           = 1'b0;
        emit              = 1'b0;
        result            = '0;

        unique case (phase_reg) inside
            PH_PTAG, PH_FTAG:
            begin
                is_frame = (phase_reg == PH_FTAG);
                if (in_byte == (is_frame ? TAG_FRAME : TAG_PREAMBLE))
                begin
                    phase_next        = is_frame ? PH_FLEN : PH_PLEN;
                    header_count_next = 2'd0;
                    length_accum_next = '0;
                end
                else
                begin
                    emit                = 1'b1;
                    bad_tag             = 1'b1;
                    result.segment_kind = is_frame;
                    result.status       = is_frame ? tlsd_pkg::STATUS_BAD_FRAME
                                                   : tlsd_pkg::STATUS_BAD_PREAMBLE;
                    phase_next          = PH_ERR;
                end
            end
            PH_PLEN, PH_FLEN:
            begin
                is_frame          = (phase_reg == PH_FLEN);
                length_accum_next = accum_shift;
                header_count_next = header_count_reg + 2'd1;
                if (header_count_reg == 2'd3)
                begin
                    if (accum_shift == 32'd0)
                    begin
                        // empty segment: one marker result
                        emit                = 1'b1;
                        result.segment_kind = is_frame;
                        result.segment_end  = 1'b1;
                        phase_next          = is_frame ? PH_PTAG : PH_FTAG;
                    end
                    else
                    begin
                        bytes_left_next = accum_shift;
                        phase_next      = is_frame ? PH_FDATA : PH_PDATA;
                    end
                end
            end
            PH_PDATA, PH_FDATA:
            begin
                is_frame            = (phase_reg == PH_FDATA);
                emit                = 1'b1;
                result.out_byte     = in_byte;
                result.has_byte     = 1'b1;
                result.segment_kind = is_frame;
                bytes_left_next     = bytes_dec;
                if (bytes_dec == 32'd0)
                begin
                    result.segment_end = 1'b1;
                    phase_next         = is_frame ? PH_PTAG : PH_FTAG;
                end
            end
            default:
            begin
                // error wait and the spare code
                phase_next = PH_ERR;
            end
        endcase

        if (last)
        begin
            if (!bad_tag && (phase_next != PH_ERR))
            begin
                emit = 1'b1;
                if (phase_next == PH_PTAG)
                    result.stream_end = 1'b1;
                else
                    result.status = tlsd_pkg::STATUS_TRUNC;
            end
            phase_next        = PH_PTAG;
            header_count_next = 2'd0;
            length_accum_next = '0;
            bytes_left_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PTAG;
            header_count_reg <= 2'd0;
            length_accum_reg <= '0;
            bytes_left_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            length_accum_reg <= length_accum_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

`ifndef SYNTH
    a_phase_not_spare: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_SPARE)
        else $error("parser phase reached spare code");

    a_count_only_in_length: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg != 2'd0 |-> (phase_reg == PH_PLEN || phase_reg == PH_FLEN))
        else $error("length byte count set outside a length field");

    a_payload_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PDATA || phase_reg == PH_FDATA) |-> bytes_left_reg != 32'd0)
        else $error("payload phase with no bytes left");
`endif

endmodule

[bench/tb.sv]
// self-checking bench for tagged_length_segment_deframer_core
// depends on tlsd_pkg (result type, status codes) and the core rtl

`timescale 1ns / 1ps

module tb;

    // segment tags on the wire
    localparam logic [7:0] TAG_PREAMBLE = 8'h01;
    localparam logic [7:0] TAG_FRAME    = 8'h02;

    // deframer position within a segment pair
    typedef enum logic [2:0]
    {
        PH_PRE_TAG,
        PH_PRE_LEN,
        PH_PRE_DATA,
        PH_FRM_TAG,
        PH_FRM_LEN,
        PH_FRM_DATA,
        PH_SKIP
    } deframe_phase_t;

    // shadow deframer plus the queue of results it still owes
    class deframe_scoreboard;
        deframe_phase_t    phase;
        logic [1:0]        header_count;
        logic [31:0]       length_accum;
        logic [31:0]       bytes_left;
        tlsd_pkg::result_t owed_q[$];
        int unsigned       fails;

        function new();
            restart();
            fails = 0;
        endfunction

        function void restart();
            phase        = PH_PRE_TAG;
            header_count = 2'd0;
            length_accum = 32'd0;
            bytes_left   = 32'd0;
        endfunction

        // advance the shadow state by one accepted byte request
        function void note_request(logic [7:0] b, logic is_last);
            tlsd_pkg::result_t r;
            logic              emit;
            logic              bad_tag;
            logic              is_frame;
            r        = '0;
            emit     = 1'b0;
            bad_tag  = 1'b0;
            is_frame = (phase == PH_FRM_TAG || phase == PH_FRM_LEN || phase == PH_FRM_DATA);
            case (phase)
                PH_PRE_TAG, PH_FRM_TAG:
                begin
                    if (b == (is_frame ? TAG_FRAME : TAG_PREAMBLE))
                    begin
                        phase        = is_frame ? PH_FRM_LEN : PH_PRE_LEN;
                        header_count = 2'd0;
                        length_accum = 32'd0;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        bad_tag        = 1'b1;
                        r.segment_kind = is_frame;
                        r.status       = is_frame ? tlsd_pkg::STATUS_BAD_FRAME
                                                  : tlsd_pkg::STATUS_BAD_PREAMBLE;
                        phase          = PH_SKIP;
                    end
                end
                PH_PRE_LEN, PH_FRM_LEN:
                begin
                    length_accum = {length_accum[23:0], b};
                    if (header_count == 2'd3)
                    begin
                        header_count = 2'd0;
                        if (length_accum == 32'd0)
                        begin
                            // empty segment gives a bare end marker
                            emit           = 1'b1;
                            r.segment_kind = is_frame;
                            r.segment_end  = 1'b1;
                            phase          = is_frame ? PH_PRE_TAG : PH_FRM_TAG;
                        end
                        else
                        begin
                            bytes_left = length_accum;
                            phase      = is_frame ? PH_FRM_DATA : PH_PRE_DATA;
                        end
                    end
                    else
                    begin
                        header_count = header_count + 2'd1;
                    end
                end
                PH_PRE_DATA, PH_FRM_DATA:
                begin
                    emit           = 1'b1;
                    r.out_byte     = b;
                    r.has_byte     = 1'b1;
                    r.segment_kind = is_frame;
                    bytes_left     = bytes_left - 32'd1;
                    if (bytes_left == 32'd0)
                    begin
                        r.segment_end = 1'b1;
                        phase         = is_frame ? PH_PRE_TAG : PH_FRM_TAG;
                    end
                end
                default:
                begin
                    phase = PH_SKIP;
                end
            endcase
            if (is_last)
            begin
                // clean end or truncation merges into this byte's result
                if (!bad_tag && phase != PH_SKIP)
                begin
                    emit = 1'b1;
                    if (phase == PH_PRE_TAG)
                        r.stream_end = 1'b1;
                    else
                        r.status = tlsd_pkg::STATUS_TRUNC;
                end
                restart();
            end
            if (emit)
                owed_q = {owed_q, r};
        endfunction

        function void check_result(tlsd_pkg::result_t got);
            tlsd_pkg::result_t want;
            if (owed_q.size() == 0)
            begin
                $error("result request with nothing owed: %p", got);
                fails++;
                return;
            end
            want = owed_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                fails++;
            end
            if (got.has_byte !== want.has_byte)
            begin
                $error("has_byte: expected %0d, got %0d", want.has_byte, got.has_byte);
                fails++;
            end
            if (got.segment_kind !== want.segment_kind)
            begin
                $error("segment_kind: expected %0d, got %0d",
                       want.segment_kind, got.segment_kind);
                fails++;
            end
            if (got.segment_end !== want.segment_end)
            begin
                $error("segment_end: expected %0d, got %0d",
                       want.segment_end, got.segment_end);
                fails++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.stream_end !== want.stream_end)
            begin
                $error("stream_end: expected %0d, got %0d",
                       want.stream_end, got.stream_end);
                fails++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       segment_kind;
    logic       segment_end;
    logic [1:0] status;
    logic       stream_end;

    deframe_scoreboard sb;

    // bytes of the stream being assembled, sent in order with last on the final one
    logic [7:0]  stream_q[$];
    int unsigned bytes_sent;
    logic        idle_on;
    logic        stall_on;

    tagged_length_segment_deframer_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .segment_kind (segment_kind),
        .segment_end  (segment_end),
        .status       (status),
        .stream_end   (stream_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop, far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    // both handshakes observed at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(in_byte, last);
            if (out_valid && !out_stall)
                sb.check_result({out_byte, has_byte, segment_kind, segment_end,
                                 status, stream_end});
        end
    end

    // consumer back-pressure in random bursts, changed on the falling edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one byte request and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        last     <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // send the assembled stream, flagging its final byte as last
    task automatic play_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
        stream_q.delete();
    endtask

    // sender holds off until every owed result has come back
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(posedge clk);
    endtask

    // mostly short segments, some empty, a few longer
    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return 0;
        else if (sel < 9)
            return $urandom_range(1, 6);
        else
            return $urandom_range(7, 24);
    endfunction

    task automatic push_header(input logic [7:0] tag, input logic [31:0] len);
        stream_q = {stream_q, tag, len[31:24], len[23:16], len[15:8], len[7:0]};
    endtask

    task automatic push_segment(input logic [7:0] tag, input int unsigned len);
        push_header(tag, len);
        repeat (len) stream_q = {stream_q, 8'($urandom_range(0, 255))};
    endtask

    task automatic push_pairs(input int unsigned n);
        repeat (n)
        begin
            push_segment(TAG_PREAMBLE, pick_length());
            push_segment(TAG_FRAME, pick_length());
        end
    endtask

    // one random stream: clean, cut short, broken tag, huge length or noise
    task automatic build_random_stream();
        int unsigned sel;
        logic [7:0]  bad;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            push_pairs($urandom_range(1, 3));
        end
        else if (sel == 6)
        begin
            push_pairs($urandom_range(1, 2));
            stream_q = stream_q[0 : $urandom_range(0, stream_q.size() - 2)];
        end
        else if (sel == 7)
        begin
            // valid prefix, then a tag that does not match, then ignored junk
            push_pairs($urandom_range(0, 2));
            bad = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 0)
            begin
                push_segment(TAG_PREAMBLE, pick_length());
                if (bad == TAG_FRAME)
                    bad = ~bad;
            end
            else if (bad == TAG_PREAMBLE)
            begin
                bad = ~bad;
            end
            stream_q = {stream_q, bad};
            repeat ($urandom_range(0, 4)) stream_q = {stream_q, 8'($urandom_range(0, 255))};
        end
        else if (sel == 8)
        begin
            // wide length field, stream stops inside the payload
            push_pairs($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 0)
                push_header(TAG_PREAMBLE, $urandom);
            else
            begin
                push_segment(TAG_PREAMBLE, pick_length());
                push_header(TAG_FRAME, $urandom);
            end
            repeat ($urandom_range(0, 4)) stream_q = {stream_q, 8'($urandom_range(0, 255))};
        end
        else
        begin
            repeat ($urandom_range(1, 6)) stream_q = {stream_q, 8'($urandom_range(0, 255))};
        end
    endtask

    initial
    begin
        int unsigned wait_cycles;
        sb         = new();
        bytes_sent = 0;
        idle_on    = 1'b0;
        stall_on   = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = 8'd0;
        last       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one byte preamble, empty frame closing the stream cleanly
        stream_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAA,
                     8'h02, 8'h00, 8'h00, 8'h00, 8'h00};
        play_stream();
        // bad preamble tag that is also the last byte
        stream_q = '{8'hFF};
        play_stream();
        // empty preamble, bad frame tag, then bytes swallowed up to last
        stream_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h02, 8'h00};
        play_stream();
        // all-ones length, stream ends on the first payload byte
        stream_q = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55};
        play_stream();
        // ends inside the length field, bare truncation report
        stream_q = '{8'h01, 8'h00, 8'h00};
        play_stream();
        hold_until_drained();

        // random streams, idling switched per stream, none near the end
        while (bytes_sent < 650)
        begin
            if (bytes_sent < 540)
            begin
                idle_on  = $urandom_range(0, 3) != 0;
                stall_on = $urandom_range(0, 3) != 0;
            end
            else
            begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            build_random_stream();
            play_stream();
            if ($urandom_range(0, 14) == 0)
                hold_until_drained();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        last     <= 1'b0;
        stall_on = 1'b0;
        wait_cycles = 0;
        while (sb.owed_q.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (sb.owed_q.size() != 0)
        begin
            $error("%0d results never arrived", sb.owed_q.size());
            sb.fails++;
        end

        if (sb.fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
